FILE: design/dhq_pkg.sv
// Shared types, constants and helper functions for the d-ary heap queue.
`timescale 1ns / 1ps
package dhq_pkg;

  localparam int HEAP_DEPTH = 1024;
  localparam int MAX_ARITY  = 8;
  localparam int DATA_W     = 32;
  localparam int IDX_W      = $clog2(HEAP_DEPTH);
  localparam int CNT_W      = IDX_W + 1;
  localparam int ARITY_W    = 4;
  localparam int CHILD_W    = IDX_W + ARITY_W;
  localparam int RECIP_SH   = IDX_W + 6;
  localparam int RECIP_W    = RECIP_SH;

  // Reciprocals rounded up, so (x * RC) >> RECIP_SH equals x / d for every index.
  localparam int RC2 = ((2 ** RECIP_SH) + 1) / 2;
  localparam int RC3 = ((2 ** RECIP_SH) + 2) / 3;
  localparam int RC4 = ((2 ** RECIP_SH) + 3) / 4;
  localparam int RC5 = ((2 ** RECIP_SH) + 4) / 5;
  localparam int RC6 = ((2 ** RECIP_SH) + 5) / 6;
  localparam int RC7 = ((2 ** RECIP_SH) + 6) / 7;
  localparam int RC8 = ((2 ** RECIP_SH) + 7) / 8;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_EXTRACT  = 2'd1,
    OP_INCREASE = 2'd2,
    OP_UNUSED   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_EX_RD1, S_EX_CAP, S_UP_RD, S_UP_CMP, S_UP_END,
    S_DN_INIT, S_DN_RD, S_DN_CMP, S_DN_END, S_SR_RD, S_SR_CMP, S_RESP
  } state_t;

  typedef enum logic [3:0] {
    CMD_NOP, CMD_LOAD, CMD_INS_INIT, CMD_EX_RD0, CMD_EX_RD1, CMD_EX_CAP,
    CMD_UP_RD, CMD_UP_SWAP, CMD_WR_CUR, CMD_DN_INIT, CMD_DN_RD, CMD_DN_CMP,
    CMD_DN_MOVE, CMD_SR_INIT, CMD_SR_RD, CMD_SR_NEXT
  } dp_cmd_t;

  typedef struct packed {
    dp_cmd_t cmd;
    logic    sr_hit_take;
    logic    set_status;
    status_e status;
  } ctrl_cmd_t;

  typedef struct packed {
    op_e  op;
    logic full;
    logic empty;
    logic at_root;
    logic up_gt;
    logic dn_end;
    logic best_found;
    logic sr_end;
    logic sr_hit;
    logic moved;
  } dp_stat_t;

  function automatic logic [ARITY_W-1:0] eff_arity(input logic [ARITY_W-1:0] a);
    logic [ARITY_W-1:0] d;
    d = a;
    if (a < ARITY_W'(2)) d = ARITY_W'(2);
    if (a > ARITY_W'(MAX_ARITY)) d = ARITY_W'(MAX_ARITY);
    return d;
  endfunction

  function automatic logic [RECIP_W-1:0] recip(input logic [ARITY_W-1:0] d);
    logic [RECIP_W-1:0] r;
    case (d)
      ARITY_W'(3): r = RECIP_W'(RC3);
      ARITY_W'(4): r = RECIP_W'(RC4);
      ARITY_W'(5): r = RECIP_W'(RC5);
      ARITY_W'(6): r = RECIP_W'(RC6);
      ARITY_W'(7): r = RECIP_W'(RC7);
      ARITY_W'(8): r = RECIP_W'(RC8);
      default:     r = RECIP_W'(RC2);
    endcase
    return r;
  endfunction

endpackage

FILE: design/dhq_if.sv
// Valid/ready channel interfaces for the heap queue's items and results.
`timescale 1ns / 1ps
interface dhq_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic signed [31:0] value;
  logic signed [31:0] step;
  modport source (output valid, operation, value, step, input ready);
  modport sink   (input valid, operation, value, step, output ready);
endinterface

interface dhq_out_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] result_value;
  logic [1:0]        status;
  logic [10:0]       entry_count;
  modport source (output valid, result_value, status, entry_count, input ready);
  modport sink   (input valid, result_value, status, entry_count, output ready);
endinterface

FILE: design/dhq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module dhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: design/dhq_datapath.sv
// Heap datapath: entry store, count, moving entry, child scan and result registers.
`timescale 1ns / 1ps
module dhq_datapath import dhq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [ARITY_W-1:0] cfg_wdata,
  input  logic [1:0]         in_operation,
  input  logic [DATA_W-1:0]  in_value,
  input  logic [DATA_W-1:0]  in_step,
  input  ctrl_cmd_t          cmd,
  output dp_stat_t           stat,
  output logic [DATA_W-1:0]  result_value,
  output logic [1:0]         status,
  output logic [CNT_W-1:0]   entry_count
);
  logic [ARITY_W-1:0] arity;
  logic [ARITY_W-1:0] d;
  logic [CNT_W-1:0]   count;
  op_e                op;
  logic [DATA_W-1:0]  key;
  logic [DATA_W-1:0]  step;
  logic [DATA_W-1:0]  res_val;
  status_e            st;
  logic [DATA_W-1:0]  cur_val;
  logic [IDX_W-1:0]   cur_idx;
  logic [IDX_W-1:0]   par_idx;
  logic [CHILD_W-1:0] child_idx;
  logic [ARITY_W-1:0] k;
  logic [DATA_W-1:0]  best_val;
  logic [IDX_W-1:0]   best_idx;
  logic               best_found;
  logic               moved;

  logic                       we;
  logic [IDX_W-1:0]           waddr;
  logic [DATA_W-1:0]          wdata;
  logic [IDX_W-1:0]           raddr;
  logic [DATA_W-1:0]          rdata;
  logic [IDX_W+RECIP_W-1:0]   par_prod;
  logic [IDX_W-1:0]           parent;
  logic [CHILD_W-1:0]         first_child;
  logic [DATA_W:0]            sum;
  logic [DATA_W-1:0]          sat_sum;

  assign d = eff_arity(arity);
  // Parent (i - 1) / d is a multiplication by a rounded-up reciprocal.
  assign par_prod    = (cur_idx - IDX_W'(1)) * recip(d);
  assign parent      = par_prod[RECIP_SH +: IDX_W];
  assign first_child = CHILD_W'(cur_idx) * CHILD_W'(d) + CHILD_W'(1);

  assign sum = {key[DATA_W-1], key} + {step[DATA_W-1], step};
  always_comb begin
    if (sum[DATA_W] != sum[DATA_W-1]) begin
      sat_sum = sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      sat_sum = sum[DATA_W-1:0];
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = cur_idx;
    wdata = cur_val;
    raddr = child_idx[IDX_W-1:0];
    case (cmd.cmd)
      CMD_EX_RD0:  raddr = '0;
      CMD_EX_RD1:  raddr = count[IDX_W-1:0];
      CMD_UP_RD:   raddr = parent;
      CMD_UP_SWAP: begin
        we    = 1'b1;
        wdata = rdata;
      end
      CMD_WR_CUR:  we = 1'b1;
      CMD_DN_MOVE: begin
        we    = 1'b1;
        wdata = best_val;
      end
      default: ;
    endcase
  end

  dhq_ram #(.WIDTH(DATA_W), .DEPTH(HEAP_DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      arity <= ARITY_W'(2);
    end else if (cfg_we) begin
      arity <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cmd == CMD_INS_INIT) begin
      count <= count + CNT_W'(1);
    end else if (cmd.cmd == CMD_EX_RD0) begin
      count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_status) begin
      st <= cmd.status;
    end
    case (cmd.cmd)
      CMD_LOAD: begin
        op      <= op_e'(in_operation);
        key     <= in_value;
        step    <= in_step;
        res_val <= '0;
      end
      CMD_INS_INIT: begin
        cur_val <= key;
        cur_idx <= count[IDX_W-1:0];
        moved   <= 1'b0;
      end
      CMD_EX_RD1:  res_val <= rdata;
      CMD_EX_CAP: begin
        cur_val <= rdata;
        cur_idx <= '0;
      end
      CMD_UP_RD:   par_idx <= parent;
      CMD_UP_SWAP: begin
        cur_idx <= par_idx;
        moved   <= 1'b1;
      end
      CMD_DN_INIT: begin
        child_idx  <= first_child;
        k          <= '0;
        best_val   <= cur_val;
        best_found <= 1'b0;
      end
      CMD_DN_CMP: begin
        if ($signed(rdata) > $signed(best_val)) begin
          best_val   <= rdata;
          best_idx   <= child_idx[IDX_W-1:0];
          best_found <= 1'b1;
        end
        child_idx <= child_idx + CHILD_W'(1);
        k         <= k + ARITY_W'(1);
      end
      CMD_DN_MOVE: cur_idx <= best_idx;
      CMD_SR_INIT: child_idx <= '0;
      CMD_SR_NEXT: begin
        if (cmd.sr_hit_take) begin
          cur_val <= sat_sum;
          cur_idx <= child_idx[IDX_W-1:0];
          moved   <= 1'b0;
        end else begin
          child_idx <= child_idx + CHILD_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.op         = op;
    stat.full       = (count == CNT_W'(HEAP_DEPTH));
    stat.empty      = (count == '0);
    stat.at_root    = (cur_idx == '0);
    stat.up_gt      = ($signed(cur_val) > $signed(rdata));
    stat.dn_end     = (child_idx >= CHILD_W'(count)) || (k == d);
    stat.best_found = best_found;
    stat.sr_end     = (child_idx >= CHILD_W'(count));
    stat.sr_hit     = (rdata == key);
    stat.moved      = moved;
  end

  assign result_value = res_val;
  assign status       = st;
  assign entry_count  = count;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(HEAP_DEPTH)) else $error("entry count above depth");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |->
      (count == $past(count) + CNT_W'(1) || count == $past(count) - CNT_W'(1)))
    else $error("entry count moved by more than one");
endmodule

FILE: design/dhq_ctrl.sv
// Controller state machine that sequences insert, extract, search and sifting.
`timescale 1ns / 1ps
module dhq_ctrl import dhq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    cmd.cmd         = CMD_NOP;
    cmd.sr_hit_take = 1'b0;
    cmd.set_status  = 1'b0;
    cmd.status      = ST_OK;
    in_ready        = 1'b0;
    out_valid       = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cmd        = CMD_LOAD;
          cmd.set_status = 1'b1;
          state_next     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.op)
          OP_INSERT: begin
            if (stat.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL;
              state_next     = S_RESP;
            end else begin
              cmd.cmd    = CMD_INS_INIT;
              state_next = S_UP_RD;
            end
          end
          OP_EXTRACT: begin
            if (stat.empty) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_EMPTY;
              state_next     = S_RESP;
            end else begin
              cmd.cmd    = CMD_EX_RD0;
              state_next = S_EX_RD1;
            end
          end
          OP_INCREASE: begin
            cmd.cmd    = CMD_SR_INIT;
            state_next = S_SR_RD;
          end
          default: state_next = S_RESP;
        endcase
      end
      S_EX_RD1: begin
        cmd.cmd    = CMD_EX_RD1;
        state_next = S_EX_CAP;
      end
      S_EX_CAP: begin
        cmd.cmd    = CMD_EX_CAP;
        state_next = S_DN_INIT;
      end
      S_SR_RD: begin
        if (stat.sr_end) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_NOTFOUND;
          state_next     = S_RESP;
        end else begin
          cmd.cmd    = CMD_SR_RD;
          state_next = S_SR_CMP;
        end
      end
      S_SR_CMP: begin
        cmd.cmd         = CMD_SR_NEXT;
        cmd.sr_hit_take = stat.sr_hit;
        state_next      = stat.sr_hit ? S_UP_RD : S_SR_RD;
      end
      S_UP_RD: begin
        if (stat.at_root) begin
          state_next = S_UP_END;
        end else begin
          cmd.cmd    = CMD_UP_RD;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat.up_gt) begin
          cmd.cmd    = CMD_UP_SWAP;
          state_next = S_UP_RD;
        end else begin
          state_next = S_UP_END;
        end
      end
      S_UP_END: begin
        // An increased key that did not rise may still have to sink.
        if (stat.op == OP_INCREASE && !stat.moved) begin
          state_next = S_DN_INIT;
        end else begin
          cmd.cmd    = CMD_WR_CUR;
          state_next = S_RESP;
        end
      end
      S_DN_INIT: begin
        cmd.cmd    = CMD_DN_INIT;
        state_next = S_DN_RD;
      end
      S_DN_RD: begin
        if (stat.dn_end) begin
          state_next = S_DN_END;
        end else begin
          cmd.cmd    = CMD_DN_RD;
          state_next = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        cmd.cmd    = CMD_DN_CMP;
        state_next = S_DN_RD;
      end
      S_DN_END: begin
        if (stat.best_found) begin
          cmd.cmd    = CMD_DN_MOVE;
          state_next = S_DN_INIT;
        end else begin
          cmd.cmd    = CMD_WR_CUR;
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && in_ready)) else $error("item taken while result pending");
  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP && !out_ready) |=> state == S_RESP)
    else $error("result dropped before it was taken");
  a_load_next: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == S_DISPATCH)
    else $error("accepted item not dispatched");
endmodule

FILE: design/dary_max_heap_queue_core.sv
// Top level of the d-ary max-heap priority queue.
// Holds up to 1024 signed 32-bit entries as a max-heap with 2 to 8 children per
// node (arity register, reset 2, out-of-range values clamp). Each item is
// insert, extract-maximum or increase-key and yields one result carrying the
// extracted value, a status and the entry count. Items are handled one at a
// time through a single-port-read heap RAM: a sift step reads and compares
// the parent at each level going up and scans up to d children at each level
// going down, and increase-key first scans the stored entries for one equal to
// the key. No clearing pass is needed after reset.
`timescale 1ns / 1ps
module dary_max_heap_queue_core import dhq_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                cfg_we,
  input logic [ARITY_W-1:0]  cfg_wdata,
  dhq_in_if.sink             in_ch,
  dhq_out_if.source          out_ch
);
  dp_stat_t         stat;
  ctrl_cmd_t        cmd;
  logic [DATA_W-1:0] result_value;

  dhq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dhq_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_operation (in_ch.operation),
    .in_value     (in_ch.value),
    .in_step      (in_ch.step),
    .cmd          (cmd),
    .stat         (stat),
    .result_value (result_value),
    .status       (out_ch.status),
    .entry_count  (out_ch.entry_count)
  );

  assign out_ch.result_value = $signed(result_value);
endmodule
